@@ hw/rtl/two_level_lru_writeback_cache_model_macros.svh @@
// Assertion macros for the two-level cache model.
`ifndef TWO_LEVEL_LRU_WRITEBACK_CACHE_MODEL_MACROS_SVH
`define TWO_LEVEL_LRU_WRITEBACK_CACHE_MODEL_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TLC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define TLC_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/tlc_pkg.sv @@
// Package for the two-level cache model: geometry, entry type and sequencer states.
package tlc_pkg;

    localparam int L1_SET_COUNT     = 64;
    localparam int L2_SET_COUNT     = 512;
    localparam int WAY_COUNT        = 8;
    localparam int LINE_OFFSET_BITS = 6;

    localparam int ADDR_W  = 64;
    localparam int LINE_W  = ADDR_W - LINE_OFFSET_BITS;
    localparam int L1_IDX_W = $clog2(L1_SET_COUNT);
    localparam int L2_IDX_W = $clog2(L2_SET_COUNT);
    localparam int WAY_W    = $clog2(WAY_COUNT);

    typedef struct packed {
        logic              valid;
        logic              dirty;
        logic [LINE_W-1:0] line;
    } entry_t;

    typedef entry_t [WAY_COUNT-1:0] row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD1,
        ST_LK1,
        ST_LK2,
        ST_RDV,
        ST_LKV,
        ST_DONE
    } state_t;

endpackage

@@ hw/rtl/two_level_lru_writeback_cache_model.sv @@
// Top level of the two-level LRU write-back cache model.
//
//  channel | signals                                   | handshake
//  access  | address, store                            | start & !busy
//  result  | was_write, l1_hit, l2_hit,                | done strobe, one cycle
//          | l1_victim_dirty, memory_writebacks        |
//
// An L1 hit steps through ST_RD1, ST_LK1 and ST_DONE; an L1 miss adds ST_LK2,
// and a dirty L1 victim also ST_RDV and ST_LKV (a second L2 set read-modify-write).
// Rows live in two one-port-read synchronous RAMs, one set per word; each access
// reads, updates and writes a row. After reset, a clearing pass walks L2_SET_COUNT
// rows (L1 cleared alongside) with busy high. The receiver cannot stall results.
`include "two_level_lru_writeback_cache_model_macros.svh"
module two_level_lru_writeback_cache_model
    import tlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ADDR_W-1:0] address,
    input  logic              store,
    output logic              done,
    output logic              was_write,
    output logic              l1_hit,
    output logic              l2_hit,
    output logic              l1_victim_dirty,
    output logic [1:0]        memory_writebacks
);

    row_t l1_mem [L1_SET_COUNT];
    row_t l2_mem [L2_SET_COUNT];

    row_t l1_rd_reg;
    row_t l2_rd_reg;

    logic                l1_we;
    logic [L1_IDX_W-1:0] l1_addr;
    row_t                l1_wd;
    logic                l2_we;
    logic [L2_IDX_W-1:0] l2_addr;
    row_t                l2_wd;

    always_ff @(posedge clk)
    begin
        if (l1_we)
        begin
            l1_mem[l1_addr] <= l1_wd;
        end
        l1_rd_reg <= l1_mem[l1_addr];
    end

    always_ff @(posedge clk)
    begin
        if (l2_we)
        begin
            l2_mem[l2_addr] <= l2_wd;
        end
        l2_rd_reg <= l2_mem[l2_addr];
    end

    state_t              state_reg, state_next;
    logic [L2_IDX_W:0]   clr_reg, clr_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic                wr_reg, wr_next;
    entry_t              vict_reg, vict_next;
    logic                l1h_reg, l1h_next;
    logic                l2h_reg, l2h_next;
    logic                vd_reg, vd_next;
    logic [1:0]          wb_reg, wb_next;

    function automatic row_t promote(row_t r, logic [WAY_W-1:0] k, entry_t e);
        row_t o;
        o = r;
        for (int i = 1; i < WAY_COUNT; i++)
        begin
            if (i <= int'(k))
            begin
                o[i] = r[i-1];
            end
        end
        o[0] = e;
        return o;
    endfunction

    // Way lookup over a row
    logic              hit1, hit2;
    logic [WAY_W-1:0]  way1, way2;
    logic [LINE_W-1:0] key2;

    always_comb
    begin
        hit1 = 1'b0;
        way1 = '0;
        for (int i = WAY_COUNT - 1; i >= 0; i--)
        begin
            if (l1_rd_reg[i].valid && l1_rd_reg[i].line == line_reg)
            begin
                hit1 = 1'b1;
                way1 = WAY_W'(i);
            end
        end
    end

    assign key2 = (state_reg == ST_LKV) ? vict_reg.line : line_reg;

    always_comb
    begin
        hit2 = 1'b0;
        way2 = '0;
        for (int i = WAY_COUNT - 1; i >= 0; i--)
        begin
            if (l2_rd_reg[i].valid && l2_rd_reg[i].line == key2)
            begin
                hit2 = 1'b1;
                way2 = WAY_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
        wr_reg   <= wr_next;
        vict_reg <= vict_next;
        l1h_reg  <= l1h_next;
        l2h_reg  <= l2h_next;
        vd_reg   <= vd_next;
        wb_reg   <= wb_next;
    end

    entry_t e_new;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        line_next  = line_reg;
        wr_next    = wr_reg;
        vict_next  = vict_reg;
        l1h_next   = l1h_reg;
        l2h_next   = l2h_reg;
        vd_next    = vd_reg;
        wb_next    = wb_reg;
        l1_we      = 1'b0;
        l2_we      = 1'b0;
        l1_addr    = line_reg[L1_IDX_W-1:0];
        l2_addr    = line_reg[L2_IDX_W-1:0];
        l1_wd      = l1_rd_reg;
        l2_wd      = l2_rd_reg;
        e_new      = '0;
        busy       = (state_reg != ST_IDLE);
        done       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                l1_we   = 1'b1;
                l2_we   = 1'b1;
                l1_addr = clr_reg[L1_IDX_W-1:0];
                l2_addr = clr_reg[L2_IDX_W-1:0];
                l1_wd   = '0;
                l2_wd   = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (L2_IDX_W+1)'(L2_SET_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    line_next  = address[ADDR_W-1:LINE_OFFSET_BITS];
                    wr_next    = store;
                    state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                state_next = ST_LK1;
            end
            ST_LK1:
            begin
                l1h_next = hit1;
                l2h_next = 1'b0;
                vd_next  = 1'b0;
                wb_next  = '0;
                if (hit1)
                begin
                    e_new       = l1_rd_reg[way1];
                    e_new.dirty = e_new.dirty | wr_reg;
                    l1_we       = 1'b1;
                    l1_wd       = promote(l1_rd_reg, way1, e_new);
                    state_next  = ST_DONE;
                end
                else
                begin
                    vict_next   = l1_rd_reg[WAY_COUNT-1];
                    e_new.valid = 1'b1;
                    e_new.dirty = wr_reg;
                    e_new.line  = line_reg;
                    l1_we       = 1'b1;
                    l1_wd       = promote(l1_rd_reg, WAY_W'(WAY_COUNT - 1), e_new);
                    state_next  = ST_LK2;
                end
            end
            ST_LK2:
            begin
                l2h_next = hit2;
                l2_we    = 1'b1;
                if (hit2)
                begin
                    l2_wd = promote(l2_rd_reg, way2, l2_rd_reg[way2]);
                end
                else
                begin
                    e_new.valid = 1'b1;
                    e_new.line  = line_reg;
                    l2_wd = promote(l2_rd_reg, WAY_W'(WAY_COUNT - 1), e_new);
                    wb_next = {1'b0, l2_rd_reg[WAY_COUNT-1].valid
                                     & l2_rd_reg[WAY_COUNT-1].dirty};
                end
                if (vict_reg.valid && vict_reg.dirty)
                begin
                    vd_next    = 1'b1;
                    state_next = ST_RDV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RDV:
            begin
                // read after the write of ST_LK2 lands
                l2_addr    = vict_reg.line[L2_IDX_W-1:0];
                state_next = ST_LKV;
            end
            ST_LKV:
            begin
                l2_addr = vict_reg.line[L2_IDX_W-1:0];
                l2_we   = 1'b1;
                if (hit2)
                begin
                    l2_wd[way2].dirty = 1'b1;
                end
                else
                begin
                    e_new.valid = 1'b1;
                    e_new.dirty = 1'b1;
                    e_new.line  = vict_reg.line;
                    l2_wd = promote(l2_rd_reg, WAY_W'(WAY_COUNT - 1), e_new);
                    wb_next = wb_reg + {1'b0, l2_rd_reg[WAY_COUNT-1].valid
                                              & l2_rd_reg[WAY_COUNT-1].dirty};
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign was_write         = wr_reg;
    assign l1_hit            = l1h_reg;
    assign l2_hit            = l2h_reg;
    assign l1_victim_dirty   = vd_reg;
    assign memory_writebacks = wb_reg;

    `TLC_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    `TLC_ASSERT_IMP(a_hit_excl, clk, rst_n, done && l1_hit,
        !l2_hit && !l1_victim_dirty && memory_writebacks == 2'd0)
    `TLC_ASSERT_NXT(a_done_idle, clk, rst_n, done, !busy && !done)
    `TLC_ASSERT_IMP(a_wb_range, clk, rst_n, done, memory_writebacks != 2'd3)

endmodule

@@ verif/tb_two_level_lru_writeback_cache_model.sv @@
// Testbench for the two-level LRU write-back cache model against a behavioral cache.
module tb_two_level_lru_writeback_cache_model;
    import tlc_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              wr;
        bit                drain;
    } access_t;

    typedef struct {
        logic       was_write;
        logic       l1_hit;
        logic       l2_hit;
        logic       vdirty;
        logic [1:0] wbs;
    } outcome_t;

    typedef struct {
        bit                v;
        bit                d;
        logic [LINE_W-1:0] line;
    } way_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [ADDR_W-1:0] address;
    logic              store;
    logic              done;
    logic              was_write;
    logic              l1_hit;
    logic              l2_hit;
    logic              l1_victim_dirty;
    logic [1:0]        memory_writebacks;

    access_t  pending_words[$];
    outcome_t expected_outcomes[$];
    way_t     l1_tags[L1_SET_COUNT][WAY_COUNT];
    way_t     l2_tags[L2_SET_COUNT][WAY_COUNT];
    int       mismatches;
    int       idle_cycles;
    int       gap;

    two_level_lru_writeback_cache_model dut (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int lookup_slot(ref way_t row[WAY_COUNT],
                                       input logic [LINE_W-1:0] ln);
        for (int w = 0; w < WAY_COUNT; w++)
            if (row[w].v && row[w].line == ln)
                return w;
        return -1;
    endfunction

    function automatic void shift_in(ref way_t row[WAY_COUNT], input int k, input way_t e);
        for (int i = k; i > 0; i--)
            row[i] = row[i-1];
        row[0] = e;
    endfunction

    function automatic outcome_t cache_access(logic [ADDR_W-1:0] addr, logic wr);
        outcome_t          o;
        logic [LINE_W-1:0] ln;
        int                s1;
        int                s2;
        int                sv;
        int                w;
        way_t              e;
        ln = addr[ADDR_W-1:LINE_OFFSET_BITS];
        s1 = int'(ln % L1_SET_COUNT);
        s2 = int'(ln % L2_SET_COUNT);
        o = '{wr, 1'b0, 1'b0, 1'b0, 2'd0};
        w = lookup_slot(l1_tags[s1], ln);
        if (w >= 0)
        begin
            e = l1_tags[s1][w];
            e.d = e.d | wr;
            shift_in(l1_tags[s1], w, e);
            o.l1_hit = 1'b1;
            return o;
        end
        w = lookup_slot(l2_tags[s2], ln);
        if (w >= 0)
        begin
            o.l2_hit = 1'b1;
            shift_in(l2_tags[s2], w, l2_tags[s2][w]);
        end
        else
        begin
            if (l2_tags[s2][WAY_COUNT-1].v && l2_tags[s2][WAY_COUNT-1].d)
                o.wbs++;
            shift_in(l2_tags[s2], WAY_COUNT-1, '{1, 0, ln});
        end
        e = l1_tags[s1][WAY_COUNT-1];
        if (e.v && e.d)
        begin
            o.vdirty = 1'b1;
            sv = int'(e.line % L2_SET_COUNT);
            w = lookup_slot(l2_tags[sv], e.line);
            if (w >= 0)
                l2_tags[sv][w].d = 1;
            else
            begin
                if (l2_tags[sv][WAY_COUNT-1].v && l2_tags[sv][WAY_COUNT-1].d)
                    o.wbs++;
                shift_in(l2_tags[sv], WAY_COUNT-1, '{1, 1, e.line});
            end
        end
        shift_in(l1_tags[s1], WAY_COUNT-1, '{1, wr, ln});
        return o;
    endfunction

    // addresses mostly drawn from a small pool of lines so that sets fill and evict
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] hi;
        a = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            return a;
        hi = ADDR_W'($urandom_range(0, 3));
        hi = ADDR_W'({hi[1], 1'b0, hi[0]}) << 61;
        return hi | ((ADDR_W'($urandom_range(0, 7)) * L2_SET_COUNT
            + ADDR_W'($urandom_range(0, 3)) * L1_SET_COUNT
            + ADDR_W'($urandom_range(0, 2))) << LINE_OFFSET_BITS) | ADDR_W'(a[5:0]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            address  <= '0;
            store    <= 1'b0;
            gap      <= 0;
        end
        else if (start && !busy)
        begin
            expected_outcomes.push_back(cache_access(address, store));
            start <= 1'b0;
            gap   <= $urandom_range(0, 3);
        end
        else if (!start && pending_words.size() > 0)
        begin
            if (gap > 0)
                gap <= gap - 1;
            else if (pending_words[0].drain && expected_outcomes.size() > 0)
                gap <= 0;
            else
            begin
                address  <= pending_words[0].addr;
                store    <= pending_words[0].wr;
                start    <= 1'b1;
                void'(pending_words.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word");
                end
                else
                begin
                    outcome_t x;
                    x = expected_outcomes.pop_front();
                    if (x.was_write !== was_write || x.l1_hit !== l1_hit
                        || x.l2_hit !== l2_hit || x.vdirty !== l1_victim_dirty
                        || x.wbs !== memory_writebacks)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp w%0b h1%0b h2%0b vd%0b wb%0d",
                                x.was_write, x.l1_hit, x.l2_hit, x.vdirty, x.wbs,
                                " got w%0b h1%0b h2%0b vd%0b wb%0d", was_write,
                                l1_hit, l2_hit, l1_victim_dirty, memory_writebacks);
                    end
                end
            end
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        access_t t;
        mismatches  = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        for (int s = 0; s < L1_SET_COUNT; s++)
            for (int w = 0; w < WAY_COUNT; w++)
                l1_tags[s][w] = '{0, 0, '0};
        for (int s = 0; s < L2_SET_COUNT; s++)
            for (int w = 0; w < WAY_COUNT; w++)
                l2_tags[s][w] = '{0, 0, '0};
        pending_words.push_back('{64'h0, 1'b0, 1'b0});
        pending_words.push_back('{64'h3f, 1'b1, 1'b0});
        pending_words.push_back('{64'hffff_ffff_ffff_ffff, 1'b1, 1'b0});
        pending_words.push_back('{64'hffff_ffff_ffff_ffc0, 1'b0, 1'b0});
        // fill one L1 set with dirty lines, then overflow it and re-touch
        for (int i = 0; i < 10; i++)
            pending_words.push_back('{ADDR_W'(i * L1_SET_COUNT) << LINE_OFFSET_BITS, 1'b1, 1'b0});
        for (int i = 0; i < 10; i++)
            pending_words.push_back('{ADDR_W'(i * L1_SET_COUNT) << LINE_OFFSET_BITS,
                1'(i & 1), i == 0});
        for (int i = 0; i < 1250; i++)
        begin
            t.addr  = pick_address();
            t.wr    = $urandom_range(0, 1);
            t.drain = (i == 600);
            pending_words.push_back(t);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_words.size() != 0 || start !== 1'b0 || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/tlc_pkg.sv
hw/rtl/two_level_lru_writeback_cache_model.sv
verif/tb_two_level_lru_writeback_cache_model.sv
